FILE: rtl/mvwd_pkg.sv
`timescale 1ns / 1ps

package mvwd_pkg;

   // Window geometry. The depth is a power of two, so the divide by the
   // squared depth in the variance is a plain right shift.
   localparam int WINDOW_DEPTH = 32;
   localparam int POS_W        = $clog2(WINDOW_DEPTH);

   // Field and accumulator widths.
   localparam int ACCEL_W  = 16;
   localparam int SAMPLE_W = ACCEL_W + 2;                  // sum of three axes
   localparam int DIFF_W   = SAMPLE_W + 1;                 // new +/- old
   localparam int PROD_W   = 2 * DIFF_W;                   // (new-old)*(new+old)
   localparam int SUM_W    = SAMPLE_W + POS_W;             // running sum
   localparam int SQSUM_W  = 2 * SAMPLE_W - 1 + POS_W;     // running sum of squares
   localparam int SUMSQ_W  = 2 * SUM_W;                    // square of running sum
   localparam int NUM_W    = SUMSQ_W;                      // N*sumsq - sum^2
   localparam int VAR_W    = 34;
   localparam int VAR_SHIFT = 2 * POS_W;

   localparam logic [VAR_W-1:0] THRESH_RESET = VAR_W'(655360);

   typedef enum logic [0:0] {
      OP_SAMPLE = 1'b0,
      OP_CLEAR  = 1'b1
   } opcode_type;

endpackage

FILE: rtl/motion_variance_wake_detector.sv
`timescale 1ns / 1ps

// Motion wake detector. Each request beat carries three signed Q7.8
// accelerometer axes, or a clear command. A sample beat adds the three axes
// and writes the sum into a 32-entry circular window, replacing the oldest
// entry; the block keeps a running sum and a running sum of squares over the
// window and returns, for every request beat, one response beat with the
// population variance floor((32*sumsq - sum^2) / 1024), a flag that is set
// once the window has wrapped, and a wake flag that is high when the window
// has filled and the variance is at or above the wake threshold. A clear
// beat zeros the window and both sums but keeps the write position and the
// filled flag, and answers with variance 0 and no wake. The block takes one
// beat per clock cycle while the response side keeps taking beats. The
// five stages are the input register, the window read and update with
// its one 19x19 multiply, the running-sum accumulators, the 23x23
// squaring of the running sum, and the final subtract, shift and
// threshold compare in the output register. Every stage holds its beat only
// while the stage after it is full, so requests keep flowing into empty
// stages while a response waits. The threshold resets to 655360 (10.0 in Q8
// squared) and is to be written through csr_wr_en and csr_wr_data only
// while the block is idle; the block itself does not enforce this.
module motion_variance_wake_detector
   import mvwd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_opcode,
   input  logic signed [ACCEL_W-1:0] req_accel_x,
   input  logic signed [ACCEL_W-1:0] req_accel_y,
   input  logic signed [ACCEL_W-1:0] req_accel_z,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic        [VAR_W-1:0]   rsp_window_variance,
   output logic                      rsp_window_filled,
   output logic                      rsp_motion_wake,

   input  logic                      csr_wr_en,
   input  logic        [VAR_W-1:0]   csr_wr_data
);

   // Stage enables: a stage may load when it is empty or its beat moves on.
   logic en1, en2, en3, en4, en5;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   assign en5 = !v5_ff || rsp_ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_ready = en1;
   assign rsp_valid = v5_ff;

   // Wake threshold register.
   logic [VAR_W-1:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // Stage 1: input register.
   opcode_type                op1_ff;
   logic signed [ACCEL_W-1:0] ax1_ff, ay1_ff, az1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req_valid) begin
         op1_ff <= opcode_type'(req_opcode);
         ax1_ff <= req_accel_x;
         ay1_ff <= req_accel_y;
         az1_ff <= req_accel_z;
      end
   end

   // Stage 2: form the new sample, swap it into the window, and compute the
   // change to the running sum and to the running sum of squares. The square
   // difference uses new^2 - old^2 = (new - old) * (new + old), so one
   // multiplier serves both squares.
   logic signed [SAMPLE_W-1:0] window_ff [WINDOW_DEPTH];
   logic        [POS_W-1:0]    pos_ff;
   logic                       filled_ff;

   logic signed [SAMPLE_W-1:0] sample;
   logic signed [SAMPLE_W-1:0] old_sample;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [DIFF_W-1:0]   total;
   logic        [POS_W-1:0]    pos_in;
   logic                       filled_in;
   logic                       load2;

   assign sample = SAMPLE_W'(ax1_ff) + SAMPLE_W'(ay1_ff) + SAMPLE_W'(az1_ff);
   assign old_sample = window_ff[pos_ff];
   assign diff  = DIFF_W'(sample) - DIFF_W'(old_sample);
   assign total = DIFF_W'(sample) + DIFF_W'(old_sample);
   assign load2 = en2 && v1_ff;

   always_comb begin
      pos_in    = pos_ff;
      filled_in = filled_ff;
      if (op1_ff == OP_SAMPLE) begin
         if (pos_ff == POS_W'(WINDOW_DEPTH - 1)) begin
            pos_in    = '0;
            filled_in = 1'b1;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
         pos_ff    <= '0;
         filled_ff <= 1'b0;
      end else if (load2) begin
         pos_ff    <= pos_in;
         filled_ff <= filled_in;
         if (op1_ff == OP_CLEAR) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
               window_ff[i] <= '0;
            end
         end else begin
            window_ff[pos_ff] <= sample;
         end
      end
   end

   opcode_type               op2_ff;
   logic                     filled2_ff;
   logic signed [DIFF_W-1:0] diff2_ff;
   logic signed [PROD_W-1:0] prod2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load2) begin
         op2_ff     <= op1_ff;
         filled2_ff <= filled_in;
         diff2_ff   <= diff;
         prod2_ff   <= diff * total;
      end
   end

   // Stage 3: running accumulators. Both track exact window totals, so the
   // sum of squares never goes negative and modular adds stay exact.
   logic signed [SUM_W-1:0]   sum_ff;
   logic        [SQSUM_W-1:0] sqsum_ff;
   opcode_type                op3_ff;
   logic                      filled3_ff;
   logic                      load3;

   assign load3 = en3 && v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff    <= 1'b0;
         sum_ff   <= '0;
         sqsum_ff <= '0;
      end else begin
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (load3) begin
            if (op2_ff == OP_CLEAR) begin
               sum_ff   <= '0;
               sqsum_ff <= '0;
            end else begin
               sum_ff   <= sum_ff + SUM_W'(diff2_ff);
               sqsum_ff <= sqsum_ff + SQSUM_W'(prod2_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         op3_ff     <= op2_ff;
         filled3_ff <= filled2_ff;
      end
   end

   // Stage 4: square of the running sum and the sum of squares scaled by
   // the depth.
   opcode_type               op4_ff;
   logic                     filled4_ff;
   logic signed [SUMSQ_W-1:0] sumsq4_ff;
   logic        [NUM_W-1:0]   scaled4_ff;
   logic                      load4;

   assign load4 = en4 && v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load4) begin
         op4_ff     <= op3_ff;
         filled4_ff <= filled3_ff;
         sumsq4_ff  <= SUMSQ_W'(sum_ff) * SUMSQ_W'(sum_ff);
         scaled4_ff <= NUM_W'(sqsum_ff) << POS_W;
      end
   end

   // Stage 5: variance, threshold compare and the output register.
   logic [NUM_W-1:0] num;
   logic [VAR_W-1:0] variance;
   logic             load5;

   assign num      = scaled4_ff - NUM_W'(sumsq4_ff);
   assign variance = num[VAR_SHIFT +: VAR_W];
   assign load5    = en5 && v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en5) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load5) begin
         rsp_window_filled <= filled4_ff;
         if (op4_ff == OP_CLEAR) begin
            rsp_window_variance <= '0;
            rsp_motion_wake     <= 1'b0;
         end else begin
            rsp_window_variance <= variance;
            rsp_motion_wake     <= filled4_ff && (variance >= thresh_ff);
         end
      end
   end

endmodule

FILE: sim/motion_window_checker.sv
`timescale 1ns / 1ps

module motion_window_checker
   import mvwd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_opcode,
   input  logic signed [ACCEL_W-1:0] req_accel_x,
   input  logic signed [ACCEL_W-1:0] req_accel_y,
   input  logic signed [ACCEL_W-1:0] req_accel_z,

   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic        [VAR_W-1:0]   rsp_window_variance,
   input  logic                      rsp_window_filled,
   input  logic                      rsp_motion_wake,

   input  logic                      csr_wr_en,
   input  logic        [VAR_W-1:0]   csr_wr_data,

   output int                        error_count,
   output int                        results_owed,
   output int                        checked_count,
   output int                        wake_count
);

   typedef logic [63:0] wide_type;

   typedef struct packed {
      logic [VAR_W-1:0] variance;
      logic             filled;
      logic             wake;
   } motion_result_type;

   // Private copy of the window state and the threshold.
   logic signed [SAMPLE_W-1:0] window_sums [WINDOW_DEPTH];
   int                         wr_pos;
   logic                       filled;
   longint                     acc_sum;
   wide_type                   acc_sqsum;
   logic [VAR_W-1:0]           threshold;

   motion_result_type pending_results [$];
   int errors   = 0;
   int checked  = 0;
   int wakes    = 0;

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
   endtask

   task automatic clear_window();
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         window_sums[i] = '0;
      end
      acc_sum   = 0;
      acc_sqsum = '0;
   endtask

   // Applies one request beat to the window and returns the response it earns.
   task automatic advance_window(input opcode_type op,
                                 input logic signed [ACCEL_W-1:0] ax,
                                 input logic signed [ACCEL_W-1:0] ay,
                                 input logic signed [ACCEL_W-1:0] az,
                                 output motion_result_type res);
      longint   s;
      longint   old;
      wide_type num;
      wide_type var64;
      if (op == OP_CLEAR) begin
         clear_window();
         res.variance = '0;
         res.filled   = filled;
         res.wake     = 1'b0;
      end else begin
         s   = longint'(ax) + longint'(ay) + longint'(az);
         old = longint'(window_sums[wr_pos]);
         window_sums[wr_pos] = s[SAMPLE_W-1:0];
         acc_sum   = acc_sum + s - old;
         acc_sqsum = acc_sqsum + wide_type'(s * s) - wide_type'(old * old);
         if (wr_pos == WINDOW_DEPTH - 1) begin
            filled = 1'b1;
         end
         wr_pos = (wr_pos + 1) % WINDOW_DEPTH;
         num   = wide_type'(WINDOW_DEPTH) * acc_sqsum - wide_type'(acc_sum * acc_sum);
         var64 = num / wide_type'(WINDOW_DEPTH * WINDOW_DEPTH);
         res.variance = var64[VAR_W-1:0];
         res.filled   = filled;
         res.wake     = filled && (res.variance >= threshold);
      end
   endtask

   always @(posedge clock) begin
      motion_result_type exp_res;
      motion_result_type new_res;
      if (reset) begin
         clear_window();
         wr_pos    = 0;
         filled    = 1'b0;
         threshold = THRESH_RESET;
         pending_results.delete();
      end else begin
         if (csr_wr_en) begin
            threshold = csr_wr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("response beat with nothing expected (var %0d)",
                                         rsp_window_variance));
            end else begin
               exp_res = pending_results.pop_front();
               checked++;
               if (rsp_motion_wake === 1'b1) begin
                  wakes++;
               end
               if (rsp_window_variance !== exp_res.variance) begin
                  report_mismatch($sformatf("variance %0d, expected %0d",
                                            rsp_window_variance, exp_res.variance));
               end
               if (rsp_window_filled !== exp_res.filled) begin
                  report_mismatch($sformatf("window_filled %b, expected %b",
                                            rsp_window_filled, exp_res.filled));
               end
               if (rsp_motion_wake !== exp_res.wake) begin
                  report_mismatch($sformatf("motion_wake %b, expected %b (var %0d)",
                                            rsp_motion_wake, exp_res.wake, exp_res.variance));
               end
            end
         end
         if (req_valid && req_ready) begin
            advance_window(opcode_type'(req_opcode), req_accel_x, req_accel_y,
                           req_accel_z, new_res);
            pending_results.push_back(new_res);
         end
      end
      error_count   <= errors;
      results_owed  <= pending_results.size();
      checked_count <= checked;
      wake_count    <= wakes;
   end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mvwd_pkg::*;

   // Overall run limit. A correct run needs a few tens of microseconds; this
   // leaves a wide margin for unlucky stall patterns.
   localparam int unsigned RUN_LIMIT_NS = 2_000_000;

   localparam logic signed [ACCEL_W-1:0] AX_MAX = 16'sh7FFF;
   localparam logic signed [ACCEL_W-1:0] AX_MIN = 16'sh8000;

   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_BEATS  = 192;
   localparam int BURST_BEATS  = 24;
   localparam int HOLDOFF_CYC  = 80;

   // Kinds of motion that a burst of samples imitates. A burst keeps one kind
   // so that the window variance settles in a range and the threshold
   // settings land on both sides of it.
   typedef enum int {
      MOTION_STILL,
      MOTION_WALK,
      MOTION_FULL,
      MOTION_EDGE
   } motion_class_type;

   logic                      clock;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   logic                      req_opcode  = OP_SAMPLE;
   logic signed [ACCEL_W-1:0] req_accel_x = '0;
   logic signed [ACCEL_W-1:0] req_accel_y = '0;
   logic signed [ACCEL_W-1:0] req_accel_z = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   logic        [VAR_W-1:0]   rsp_window_variance;
   logic                      rsp_window_filled;
   logic                      rsp_motion_wake;
   logic                      csr_wr_en   = 1'b0;
   logic        [VAR_W-1:0]   csr_wr_data = '0;

   int error_count;
   int results_owed;
   int checked_count;
   int wake_count;

   // Random idling is switched off for one whole phase so that the block
   // also sees a long run of back-to-back beats on both channels.
   bit idle_on       = 1'b1;
   bit long_hold_req = 1'b0;
   int clear_count   = 0;
   int setting_count = 0;

   motion_variance_wake_detector i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_accel_x         (req_accel_x),
      .req_accel_y         (req_accel_y),
      .req_accel_z         (req_accel_z),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_window_variance (rsp_window_variance),
      .rsp_window_filled   (rsp_window_filled),
      .rsp_motion_wake     (rsp_motion_wake),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   motion_window_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_accel_x         (req_accel_x),
      .req_accel_y         (req_accel_y),
      .req_accel_z         (req_accel_z),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_window_variance (rsp_window_variance),
      .rsp_window_filled   (rsp_window_filled),
      .rsp_motion_wake     (rsp_motion_wake),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .error_count         (error_count),
      .results_owed        (results_owed),
      .checked_count       (checked_count),
      .wake_count          (wake_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Timeout: %0d response beats still owed", results_owed);
      $display("motion_variance_wake_detector test failed");
      $finish;
   end

   // Response side. Normally ready drops in roughly one cycle in six. When
   // the stimulus asks for it, ready is held low for a long stretch while
   // the sender keeps offering beats, so the pipeline fills and the block
   // has to push back on its request channel.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYC) @(posedge clock);
         end
         rsp_ready <= !idle_on || ($urandom_range(99) >= 16);
      end
   end

   // One axis value of the given motion kind. The edge kind sticks mostly to
   // the rails and zero, which drives the sums and the variance to their
   // limits.
   function automatic logic signed [ACCEL_W-1:0] rand_axis(input motion_class_type style);
      logic [31:0] r;
      r = $urandom();
      case (style)
         MOTION_STILL: return ACCEL_W'(int'($urandom_range(0, 512)) - 256);
         MOTION_WALK:  return ACCEL_W'(int'($urandom_range(0, 8192)) - 4096);
         MOTION_FULL:  return r[ACCEL_W-1:0];
         default: begin
            case (r[1:0])
               2'd0:    return AX_MAX;
               2'd1:    return AX_MIN;
               2'd2:    return '0;
               default: return r[31:16];
            endcase
         end
      endcase
   endfunction

   // Offers one request beat and returns at the edge where it is taken.
   // Valid is only lowered when an idle gap comes before the next beat, so
   // back-to-back beats keep valid high without a glitch.
   task automatic send_beat(input opcode_type op,
                            input logic signed [ACCEL_W-1:0] ax,
                            input logic signed [ACCEL_W-1:0] ay,
                            input logic signed [ACCEL_W-1:0] az);
      if (idle_on && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      if (op == OP_CLEAR) begin
         clear_count++;
      end
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering beats and waits until every response has come back.
   // Each request beat earns exactly one response, so an empty checker queue
   // means the pipeline is empty too. The first edge lets the count include
   // the beat that was just accepted.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   // The threshold is only changed while nothing is in flight, since the
   // compare sits in the last pipeline stage.
   task automatic write_threshold(input logic [VAR_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      setting_count++;
   endtask

   initial begin
      int               phase;
      int               k;
      int               guard;
      logic [VAR_W-1:0] thresh;
      motion_class_type style;
      opcode_type       op;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed beats at the reset threshold: zero, both rails on all axes,
      // mixed rails, small values around zero, alternating bit patterns, a
      // clear with junk on the axes, back-to-back clears, and a run of
      // alternating rails that pushes the variance toward its top end while
      // the window has not yet filled.
      send_beat(OP_SAMPLE, '0, '0, '0);
      send_beat(OP_SAMPLE, AX_MAX, AX_MAX, AX_MAX);
      send_beat(OP_SAMPLE, AX_MIN, AX_MIN, AX_MIN);
      send_beat(OP_SAMPLE, AX_MAX, AX_MIN, '0);
      send_beat(OP_SAMPLE, -16'sd1, -16'sd1, -16'sd1);
      send_beat(OP_SAMPLE, 16'sd1, '0, -16'sd1);
      send_beat(OP_SAMPLE, 16'sh5555, 16'shAAAA, 16'sh5555);
      send_beat(OP_CLEAR, AX_MAX, AX_MIN, 16'shAAAA);
      send_beat(OP_SAMPLE, AX_MIN, AX_MIN, AX_MIN);
      send_beat(OP_SAMPLE, AX_MAX, AX_MAX, AX_MAX);
      send_beat(OP_CLEAR, '0, '0, '0);
      send_beat(OP_CLEAR, 16'sh5555, 16'sh5555, 16'sh5555);
      for (k = 0; k < 10; k++) begin
         if (k[0]) begin
            send_beat(OP_SAMPLE, AX_MIN, AX_MIN, AX_MIN);
         end else begin
            send_beat(OP_SAMPLE, AX_MAX, AX_MAX, AX_MAX);
         end
      end

      // Random phases, each under its own threshold. The settings include
      // zero, where every sample after the first wrap wakes, the all-ones
      // value, which no variance can reach, the top of the stated range, the
      // reset value written back, and a few values scattered across the
      // ranges that the different motion kinds produce.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       thresh = '0;
            1:       thresh = THRESH_RESET;
            2:       thresh = {VAR_W{1'b1}};
            3:       thresh = VAR_W'(50_000_000);
            4:       thresh = VAR_W'($urandom_range(0, 4_000_000));
            5:       thresh = VAR_W'(64'd9663676416);
            6:       thresh = VAR_W'({$urandom_range(0, 1), $urandom_range(0, 32'h7FFF_FFFF)});
            default: thresh = VAR_W'($urandom_range(0, 32'h3FFF_FFFF));
         endcase
         write_threshold(thresh);
         idle_on = (phase != 3);
         style = MOTION_STILL;
         for (k = 0; k < PHASE_BEATS; k++) begin
            if (k % BURST_BEATS == 0) begin
               style = motion_class_type'($urandom_range(MOTION_STILL, MOTION_EDGE));
            end
            if (phase == 2 && k == 40) begin
               long_hold_req = 1'b1;
            end
            if (phase == 5 && k == PHASE_BEATS / 2) begin
               wait_drained();
            end
            op = ($urandom_range(19) == 0) ? OP_CLEAR : OP_SAMPLE;
            send_beat(op, rand_axis(style), rand_axis(style), rand_axis(style));
         end
      end

      req_valid <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (results_owed != 0 && guard < 20000);
      repeat (12) @(posedge clock);

      $display("Covered %0d response beats, %0d with wake set, %0d clears,",
               checked_count, wake_count, clear_count);
      $display("under %0d threshold settings plus the reset value.", setting_count);
      if (results_owed != 0) begin
         $display("ERROR: %0d response beats never arrived", results_owed);
      end
      if (error_count == 0 && results_owed == 0) begin
         $display("motion_variance_wake_detector test passed");
      end else begin
         $display("motion_variance_wake_detector test failed");
      end
      $finish;
   end

endmodule
